>>> rtl/core/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg
// Types and constants shared by the serial port front end, queue and engine.
// ----------------------------------------------------------------------------
package sci_pkg;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_BUS_RD   = 3'd1;
  localparam logic [2:0] OP_BUS_WR   = 3'd2;
  localparam logic [2:0] OP_LINE_RX  = 3'd3;
  localparam logic [2:0] OP_DMA_WR   = 3'd4;
  localparam logic [2:0] OP_DMA_RD   = 3'd5;

  localparam logic [2:0] REG_SMR = 3'd0;
  localparam logic [2:0] REG_BRR = 3'd1;
  localparam logic [2:0] REG_SCR = 3'd2;
  localparam logic [2:0] REG_TDR = 3'd3;
  localparam logic [2:0] REG_SSR = 3'd4;
  localparam logic [2:0] REG_RDR = 3'd5;
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_EXT  = 1'b1;

  localparam logic [7:0] SSR_CLEARABLE = 8'hF8;
  localparam logic [7:0] MASK7         = 8'h7F;
  localparam logic [7:0] SSR_ERRORS    = 8'h38;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address;
    logic [7:0]  data;
    logic        rx_multiproc_bit;
    logic        rx_framing_error;
    logic        rx_parity_error;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_multiproc_bit;
    logic       tx_irq;
    logic       rx_irq;
    logic       error_irq;
    logic       tx_end_irq;
    logic       rx_dropped;
  } out_item_t;

  // Classified request handed from the front end to the engine.
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] sel;
    logic [7:0] data;
    logic [2:0] rx_attr;
  } cmd_t;

endpackage

>>> rtl/core/sci_ram.sv
// ----------------------------------------------------------------------------
// sci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sci_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/sci_front.sv
// ----------------------------------------------------------------------------
// sci_front
// Accepts items, decodes the register offset and queues classified requests.
// ----------------------------------------------------------------------------
module sci_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  sci_pkg::in_item_t   item_i,
  input  logic [31:0]         base_i,
  output logic                cmd_valid_o,
  output sci_pkg::cmd_t       cmd_o,
  input  logic                cmd_take_i
);
  import sci_pkg::*;

  cmd_t       buf_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic [31:0] offset;
  cmd_t       cmd_in;
  logic       acc;

  assign offset = item_i.address - base_i;
  always_comb begin
    cmd_in.op      = item_i.operation;
    cmd_in.data    = item_i.data;
    cmd_in.rx_attr = {item_i.rx_parity_error, item_i.rx_framing_error,
                      item_i.rx_multiproc_bit};
    if (offset < 32'd6) begin
      cmd_in.sel = offset[2:0];
    end else begin
      cmd_in.sel = REG_NONE;
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign acc         = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      buf_q[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (acc) wp_q <= ~wp_q;
      if (cmd_take_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, cmd_take_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("request queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_take_i |-> cmd_valid_o)
    else $error("request taken from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && acc) |=> cnt_q == 2'd1)
    else $error("request lost on entry");
endmodule

>>> rtl/core/sci_engine.sv
// ----------------------------------------------------------------------------
// sci_engine
// Register file, transmit/receive timing and receive frame queue.
// ----------------------------------------------------------------------------
module sci_engine #(
  parameter int RxQueueDepth = 16,
  parameter int TimeWidth    = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  sci_pkg::cmd_t       cmd_i,
  output logic                cmd_take_o,
  input  logic [23:0]         ext_bit_i,
  output logic                res_valid_o,
  output sci_pkg::out_item_t  res_o,
  input  logic                res_take_i
);
  import sci_pkg::*;

  localparam int QAW = $clog2(RxQueueDepth);
  localparam int CW  = $clog2(RxQueueDepth + 1);
  localparam logic [TimeWidth-1:0] TMAX = {TimeWidth{1'b1}};

  // A request runs as issue (queue read launched), then execute.
  logic        busy_q;
  cmd_t        cur_q;
  logic [7:0]  smr_q, brr_q, scr_q, tdr_q, ssr_q, rdr_q, seen_q, sb_q;
  logic        smpb_q;
  logic [TimeWidth-1:0] txr_q, rxr_q;
  logic [QAW-1:0] head_q;
  logic [CW-1:0]  cnt_q;
  logic        ov_q;
  out_item_t   ov_res_q;
  logic [10:0] rdata;

  // Frame time, registered from current mode so the multiply is off the
  // execute path. Mode registers change only through requests, and each request
  // passes through issue before execute, so the registered value is current.
  logic [TimeWidth-1:0] ft_q;
  logic [41:0] bit_st;
  logic [45:0] frame_w;
  logic [3:0]  nbits;
  always_comb begin
    if (scr_q[1] && ext_bit_i != 24'd0) begin
      bit_st = {18'd0, ext_bit_i};
    end else begin
      bit_st = ({33'd0, brr_q + 9'd0} + 42'd1) << (5 + 2 * smr_q[1:0] - (smr_q[7] ? 3 : 0));
    end
    if (smr_q[7]) nbits = 4'd8;
    else nbits = 4'd1 + (smr_q[6] ? 4'd7 : 4'd8) + ((smr_q[2] || smr_q[5]) ? 4'd1 : 4'd0)
                 + (smr_q[3] ? 4'd2 : 4'd1);
    frame_w = bit_st * nbits;
  end
  always_ff @(posedge clk_i) begin
    ft_q <= (frame_w > {{(46-TimeWidth){1'b0}}, TMAX}) ? TMAX : frame_w[TimeWidth-1:0];
  end

  logic         q_we;
  logic [QAW-1:0] q_wa;
  logic [QAW:0]   q_sum;
  sci_ram #(.Width(11), .Depth(RxQueueDepth)) u_rxq (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(q_wa),
    .wdata_i({cur_q.rx_attr, cur_q.data}), .raddr_i(head_q), .rdata_o(rdata));

  logic exec;
  assign res_valid_o = ov_q;
  assign res_o       = ov_res_q;
  assign exec        = busy_q && (!ov_q || res_take_i);
  assign cmd_take_o  = cmd_valid_i && !busy_q;

  logic [7:0] smr_d, brr_d, scr_d, tdr_d, ssr_d, rdr_d, seen_d, sb_d;
  logic       smpb_d;
  logic [TimeWidth-1:0] txr_d, rxr_d;
  logic [QAW-1:0] head_d;
  logic [CW-1:0]  cnt_d;
  out_item_t r;

  always_comb begin
    logic [7:0] clr, byt;
    logic mpb, fer, per, skip, sev, mpf;
    smr_d = smr_q; brr_d = brr_q; scr_d = scr_q; tdr_d = tdr_q; ssr_d = ssr_q;
    rdr_d = rdr_q; seen_d = seen_q; sb_d = sb_q; smpb_d = smpb_q;
    txr_d = txr_q; rxr_d = rxr_q; head_d = head_q; cnt_d = cnt_q;
    q_we = 1'b0;
    // tail slot, wrapped at the queue depth
    q_sum = {1'b0, head_q} + (QAW+1)'(cnt_q);
    q_wa = (q_sum >= (QAW+1)'(RxQueueDepth)) ? QAW'(q_sum - (QAW+1)'(RxQueueDepth))
                                              : q_sum[QAW-1:0];
    r = '0; clr = '0; skip = 1'b0;
    sev = !smr_q[7] && smr_q[6];
    mpf = !smr_q[7] && smr_q[2];
    byt = rdata[7:0]; mpb = rdata[8]; fer = rdata[9]; per = rdata[10];
    unique case (cur_q.op)
      OP_TICK: begin
        if (txr_q != '0) begin
          txr_d = txr_q - 1'b1;
          if (txr_d == '0) begin
            r.tx_valid = 1'b1; r.tx_byte = sb_q; r.tx_multiproc_bit = smpb_q;
            if (scr_q[5] && !ssr_q[7] && (ssr_q & SSR_ERRORS) == '0) begin
              sb_d = sev ? (tdr_q & MASK7) : tdr_q;
              smpb_d = mpf && ssr_q[0];
              txr_d = ft_q; ssr_d[7] = 1'b1;
            end else if (ssr_q[7]) ssr_d[2] = 1'b1;
          end
        end
        if (rxr_q != '0) begin
          rxr_d = rxr_q - 1'b1;
          if (rxr_d == '0 && cnt_q != '0) begin
            head_d = (head_q == QAW'(RxQueueDepth - 1)) ? '0 : head_q + 1'b1;
            cnt_d = cnt_q - 1'b1;
            if (scr_q[4]) begin
              if (smr_q[7]) begin fer = 1'b0; per = 1'b0; mpb = 1'b0; end
              else if (mpf || !smr_q[5]) per = 1'b0;
              if (mpf) begin
                ssr_d[1] = mpb;
                if (scr_q[3]) begin
                  if (mpb) scr_d[3] = 1'b0; else skip = 1'b1;
                end
              end
              if (!skip) begin
                if ((ssr_d & SSR_ERRORS) == '0) begin
                  if (ssr_d[6]) ssr_d[5] = 1'b1;
                  else begin
                    rdr_d = sev ? (byt & MASK7) : byt;
                    if (!fer && !per) ssr_d[6] = 1'b1;
                  end
                end
                if (fer) ssr_d[4] = 1'b1;
                if (per) ssr_d[3] = 1'b1;
              end
            end
            rxr_d = (cnt_d != '0) ? ft_q : '0;
          end
        end
      end
      OP_BUS_RD: begin
        unique case (cur_q.sel)
          REG_SMR: r.read_data = smr_q;
          REG_BRR: r.read_data = brr_q;
          REG_SCR: r.read_data = scr_q;
          REG_TDR: r.read_data = tdr_q;
          REG_SSR: begin seen_d = seen_q | (ssr_q & SSR_CLEARABLE); r.read_data = ssr_q; end
          REG_RDR: r.read_data = rdr_q;
          default: r.read_data = 8'hFF;
        endcase
      end
      OP_BUS_WR: begin
        unique case (cur_q.sel)
          REG_SMR: smr_d = cur_q.data;
          REG_BRR: brr_d = cur_q.data;
          REG_SCR: begin
            scr_d = cur_q.data;
            if (scr_q[5] && !cur_q.data[5]) begin
              txr_d = '0; ssr_d[7] = 1'b1; ssr_d[2] = 1'b1;
            end
          end
          REG_TDR: tdr_d = cur_q.data;
          REG_SSR: begin
            clr = ~cur_q.data & seen_q & SSR_CLEARABLE;
            if (!scr_q[5]) clr[7] = 1'b0;
            ssr_d = (ssr_q & ~clr & 8'hFE) | {7'd0, cur_q.data[0]};
            seen_d = seen_q & ~clr;
            if (clr[7]) ssr_d[2] = 1'b0;
            if ((clr & (SSR_ERRORS | 8'h80)) != '0 && scr_q[5] && !ssr_d[7]
                && txr_q == '0 && (ssr_d & SSR_ERRORS) == '0) begin
              sb_d = sev ? (tdr_q & MASK7) : tdr_q;
              smpb_d = mpf && ssr_d[0];
              txr_d = ft_q; ssr_d[7] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_LINE_RX: begin
        if (cnt_q >= CW'(RxQueueDepth)) r.rx_dropped = 1'b1;
        else begin
          q_we = exec; cnt_d = cnt_q + 1'b1;
          if (rxr_q == '0) rxr_d = ft_q;
        end
      end
      OP_DMA_WR: begin
        tdr_d = cur_q.data;
        if (scr_q[5]) begin
          ssr_d[7] = 1'b0; ssr_d[2] = 1'b0;
          if (txr_q == '0 && (ssr_q & SSR_ERRORS) == '0) begin
            sb_d = sev ? (cur_q.data & MASK7) : cur_q.data;
            smpb_d = mpf && ssr_q[0];
            txr_d = ft_q; ssr_d[7] = 1'b1;
          end
        end
      end
      OP_DMA_RD: begin ssr_d[6] = 1'b0; r.read_data = rdr_q; end
      default: ;
    endcase
    r.tx_irq     = scr_d[7] && ssr_d[7];
    r.rx_irq     = scr_d[6] && ssr_d[6];
    r.error_irq  = scr_d[6] && ((ssr_d & SSR_ERRORS) != '0);
    r.tx_end_irq = scr_d[2] && ssr_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cur_q <= cmd_i;
    if (exec) ov_res_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ov_q <= 1'b0;
      smr_q <= 8'h00; brr_q <= 8'hFF; scr_q <= 8'h00; tdr_q <= 8'hFF;
      ssr_q <= 8'h84; rdr_q <= 8'h00; seen_q <= 8'h00; sb_q <= 8'hFF;
      smpb_q <= 1'b0; txr_q <= '0; rxr_q <= '0; head_q <= '0; cnt_q <= '0;
    end else begin
      if (cmd_take_o) busy_q <= 1'b1;
      else if (exec) busy_q <= 1'b0;
      if (exec) ov_q <= 1'b1;
      else if (res_take_i) ov_q <= 1'b0;
      if (exec) begin
        smr_q <= smr_d; brr_q <= brr_d; scr_q <= scr_d; tdr_q <= tdr_d;
        ssr_q <= ssr_d; rdr_q <= rdr_d; seen_q <= seen_d; sb_q <= sb_d;
        smpb_q <= smpb_d; txr_q <= txr_d; rxr_q <= rxr_d;
        head_q <= head_d; cnt_q <= cnt_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(RxQueueDepth))
    else $error("receive queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) exec |-> busy_q)
    else $error("execute without a request");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (cnt_q == '0) |-> (rxr_q == '0))
    else $error("receive timer running with empty queue");
endmodule

>>> rtl/core/serial_comm_interface_uart.sv
// ----------------------------------------------------------------------------
// serial_comm_interface_uart
// Serial port with SMR/BRR/SCR/TDR/SSR/RDR registers and a receive queue.
// ----------------------------------------------------------------------------
// Each item yields one result. Inside the engine an item goes through queue
// read issue, then execute; no new item is taken until the last has executed,
// and execute waits while an unpopped result is held. The front queue absorbs
// a burst of two. Frame time follows mode register changes in the next cycle.
module serial_comm_interface_uart #(
  parameter int RX_QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH     = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sci_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output sci_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import sci_pkg::*;

  logic [31:0] base_q;
  logic [23:0] ext_q;
  logic        cmd_valid, cmd_take, res_valid;
  cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; ext_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BASE) base_q <= cfg_data_i;
      else ext_q <= cfg_data_i[23:0];
    end
  end

  sci_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item_i),
    .base_i(base_q), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take));

  sci_engine #(.RxQueueDepth(RX_QUEUE_DEPTH), .TimeWidth(TIME_WIDTH)) u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .ext_bit_i(ext_q), .res_valid_o(res_valid), .res_o(out_item_o),
    .res_take_i(pop && res_valid));

  assign empty = !res_valid;
endmodule
